>>> hdl/pta_pkg.sv
package pta_pkg;

    // Running playback mode, same encoding as the initial_mode register
    typedef enum logic [1:0] {
        MODE_LOOP    = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_ONCE    = 2'd2,
        MODE_STOPPED = 2'd3
    } t_mode;

    // Step operations; code 3 is unused and leaves the state alone
    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_SET     = 2'd1,
        OP_RELOAD  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_TIME   = 2'd0,
        CFG_STOP_TIME    = 2'd1,
        CFG_INITIAL_MODE = 2'd2,
        CFG_INITIAL_RATE = 2'd3
    } t_cfg_idx;

    localparam int TIME_W = 32;   // Q16.16
    localparam int RATE_W = 16;   // Q8.8
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [RATE_W-1:0] RATE_ONE = 16'sd256;

    typedef struct packed {
        logic signed [TIME_W-1:0] start_time;
        logic signed [TIME_W-1:0] stop_time;
        t_mode                    initial_mode;
        logic signed [RATE_W-1:0] initial_rate;
    } t_cfg;

    typedef struct packed {
        logic signed [TIME_W-1:0] play_time;
        logic signed [RATE_W-1:0] rate;
        t_mode                    mode;
    } t_state;

    // Saturate a sign-extended 41-bit value to the signed 32-bit range
    function automatic logic signed [TIME_W-1:0] sat_time(input logic signed [40:0] x);
        logic signed [TIME_W-1:0] res;
        if ((x[40:31] == 10'h000) || (x[40:31] == 10'h3FF)) begin
            res = x[31:0];
        end else if (x[40]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    // Negate a rate; the most negative code saturates to the most positive
    function automatic logic signed [RATE_W-1:0] neg_rate(input logic signed [RATE_W-1:0] r);
        logic signed [RATE_W-1:0] res;
        if (r == 16'sh8000) begin
            res = 16'sh7FFF;
        end else begin
            res = 16'(-r);
        end
        return res;
    endfunction

endpackage

>>> hdl/pta_cfg_regs.sv
module pta_cfg_regs
    import pta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_time   <= '0;
            r_cfg.stop_time    <= '0;
            r_cfg.initial_mode <= MODE_LOOP;
            r_cfg.initial_rate <= RATE_ONE;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_START_TIME:   r_cfg.start_time   <= i_wr_data[TIME_W-1:0];
                CFG_STOP_TIME:    r_cfg.stop_time    <= i_wr_data[TIME_W-1:0];
                CFG_INITIAL_MODE: r_cfg.initial_mode <= t_mode'(i_wr_data[1:0]);
                CFG_INITIAL_RATE: r_cfg.initial_rate <= i_wr_data[RATE_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/pta_step.sv
module pta_step
    import pta_pkg::*;
(
    input  logic [1:0]        i_op,
    input  logic [TIME_W-1:0] i_value,
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    output t_state            o_state
);

    logic signed [TIME_W-1:0]   w_val;
    logic signed [TIME_W-1:0]   w_pt;
    logic signed [TIME_W-1:0]   w_lo;
    logic signed [TIME_W-1:0]   w_hi;
    logic signed [RATE_W-1:0]   w_rate_in;
    logic signed [47:0]         w_prod;
    logic signed [39:0]         w_scaled;
    logic signed [40:0]         w_sum;
    logic signed [TIME_W-1:0]   w_t;
    logic signed [33:0]         w_corr;
    logic signed [RATE_W-1:0]   w_rate;
    t_mode                      w_mode;

    assign w_val     = i_value;
    assign w_pt      = i_state.play_time;
    assign w_lo      = i_cfg.start_time;
    assign w_hi      = i_cfg.stop_time;
    assign w_rate_in = i_state.rate;

    // Q8.8 x Q16.16 gives Q24.24; arithmetic shift by 8 is a floor divide
    assign w_prod   = w_rate_in * w_val;
    assign w_scaled = w_prod[47:8];
    assign w_sum    = 41'(w_pt) + 41'(w_scaled);

    always_comb begin
        w_t    = sat_time(w_sum);
        w_rate = w_rate_in;
        w_mode = i_state.mode;
        w_corr = '0;
        o_state = i_state;
        unique case (i_op)
            OP_ADVANCE: begin
                if (i_state.mode != MODE_STOPPED) begin
                    // Lower bound first
                    if (w_t < w_lo) begin
                        unique case (w_mode)
                            MODE_LOOP: begin
                                w_corr = 34'(w_hi) - 34'(w_lo) + 34'(w_t);
                                w_t    = sat_time(41'(w_corr));
                            end
                            MODE_REVERSE: begin
                                w_corr = 34'(w_lo) + 34'(w_lo) - 34'(w_t);
                                w_t    = sat_time(41'(w_corr));
                                w_rate = neg_rate(w_rate);
                            end
                            MODE_ONCE: begin
                                w_t    = w_lo;
                                w_mode = MODE_STOPPED;
                            end
                            MODE_STOPPED: begin
                                w_t = w_t;
                            end
                        endcase
                    end
                    // Then upper bound, on the corrected time and mode
                    if (w_t > w_hi) begin
                        unique case (w_mode)
                            MODE_LOOP: begin
                                w_corr = 34'(w_lo) + 34'(w_t) - 34'(w_hi);
                                w_t    = sat_time(41'(w_corr));
                            end
                            MODE_REVERSE: begin
                                w_corr = 34'(w_hi) + 34'(w_hi) - 34'(w_t);
                                w_t    = sat_time(41'(w_corr));
                                w_rate = neg_rate(w_rate);
                            end
                            MODE_ONCE: begin
                                w_t    = w_hi;
                                w_mode = MODE_STOPPED;
                            end
                            MODE_STOPPED: begin
                                w_t = w_t;
                            end
                        endcase
                    end
                    o_state.play_time = w_t;
                    o_state.rate      = w_rate;
                    o_state.mode      = w_mode;
                end
            end
            OP_SET: begin
                if (w_val < w_lo) begin
                    o_state.play_time = w_lo;
                end else if (w_val > w_hi) begin
                    o_state.play_time = w_hi;
                end else begin
                    o_state.play_time = w_val;
                end
            end
            OP_RELOAD: begin
                o_state.mode = i_cfg.initial_mode;
                o_state.rate = i_cfg.initial_rate;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> hdl/playback_time_accumulator_unit.sv
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  ------------------------------
// in        sink       i_in_valid / o_in_stall       i_op, i_value_in
// out       source     o_out_valid / i_out_stall     o_time_out, o_mode_out, o_rate_out
// cfg       sink       i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the result side does not stall; each word
// goes from the input register to the result register in one multiply-add-correct pass.
// The single state update per cycle is the loop that sets the rate: the next
// word's multiply needs the rate and time this word leaves behind.
// Reset is synchronous, active low: state goes to time 0, rate one, loop mode.
// A stall on the result side holds the result and backs up through o_in_stall.
module playback_time_accumulator_unit
    import pta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic [TIME_W-1:0]     i_value_in,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TIME_W-1:0]     o_time_out,
    output logic [1:0]            o_mode_out,
    output logic [RATE_W-1:0]     o_rate_out,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic [1:0]        r_in_op;
    logic [TIME_W-1:0] r_in_value;

    t_state            r_state;
    t_state            n_state;

    logic              r_out_valid;
    t_state            r_out;

    t_cfg              w_cfg;
    logic              w_in_accept;
    logic              w_fire;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;

    pta_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Fire a step whenever a word waits and the result register is free or
    // being emptied this cycle
    assign w_fire      = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall  = r_in_valid & ~w_fire;
    assign w_in_accept = i_in_valid & ~o_in_stall;

    // Input register: load on accept, drop once the step fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_op    <= i_op;
            r_in_value <= i_value_in;
        end
    end

    pta_step u_step (
        .i_op    (r_in_op),
        .i_value (r_in_value),
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .o_state (n_state)
    );

    // Playback state: advance only on a fired step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.play_time <= '0;
            r_state.rate      <= RATE_ONE;
            r_state.mode      <= MODE_LOOP;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Result register: capture the new state, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_time_out  = r_out.play_time;
    assign o_mode_out  = r_out.mode;
    assign o_rate_out  = r_out.rate;

`ifndef SYNTH
    // A shown result always matches the running state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out == r_state))
        else $error("result register differs from running state");

    // Stopped mode holds the whole state across an advance
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_op == OP_ADVANCE) && (r_state.mode == MODE_STOPPED))
        |=> $stable(r_state))
        else $error("advance changed state in stopped mode");

    // Only a reload leaves stopped mode
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state.mode == MODE_STOPPED) && !(w_fire && (r_in_op == OP_RELOAD)))
        |=> (r_state.mode == MODE_STOPPED))
        else $error("stopped mode left without reload");

    // A set with an ordered range lands inside it
    a_set_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_op == OP_SET) && (w_cfg.start_time <= w_cfg.stop_time))
        |=> ((r_state.play_time >= w_cfg.start_time)
             && (r_state.play_time <= w_cfg.stop_time)))
        else $error("set time outside range");

    // A waiting word is never lost while the result side stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("pending input word dropped");
`endif

endmodule
